[rtl/rgbc_pkg.sv]
// Shared types and constants for the 3x3 RGB convolution block.
// No dependencies; imported by every module of the block but the checker.
package rgbc_pkg;

   localparam int PIX_W        = 8;
   localparam int COEF_W       = 16;
   localparam int WIN_ROWS     = 3;
   localparam int WIN_TAPS     = WIN_ROWS * WIN_ROWS;
   localparam int CHANNELS     = 3;
   localparam int WIDTH_REG_W  = 11;
   localparam int HEIGHT_REG_W = 13;
   localparam int COEF_ROW_W   = 48;
   localparam int CSR_ADDR_W   = 6;
   localparam int CSR_DATA_W   = 64;
   localparam int PROD_W       = 24;
   localparam int SUM_W        = 28;
   localparam int FRAC_W       = 8;

   localparam logic [PIX_W-1:0]      PIX_MAX        = 8'd255;
   localparam logic [COEF_ROW_W-1:0] COEF_MID_RESET = 48'h0000_0100_0000;

   // red in the low byte
   typedef struct packed {
      logic [PIX_W-1:0] blue;
      logic [PIX_W-1:0] green;
      logic [PIX_W-1:0] red;
   } pixel_type;

   // tap index is row * 3 + col, col 2 newest
   typedef pixel_type [WIN_TAPS-1:0] window_type;

   // row 0 above, 1 current, 2 below
   typedef logic [WIN_ROWS-1:0][COEF_ROW_W-1:0] coef_rows_type;

   typedef struct packed {
      logic prod_load;
      logic result_load;
   } filter_ctrl_type;

   typedef enum logic [2:0] {
      REG_WIDTH       = 3'd0,
      REG_HEIGHT      = 3'd1,
      REG_COEF_TOP    = 3'd2,
      REG_COEF_MID    = 3'd3,
      REG_COEF_BOTTOM = 3'd4
   } reg_index_type;

endpackage

[rtl/rgbc_line_store.sv]
// Two line stores sharing one column address, with read bypass of same-cycle writes.
// Depends on rgbc_pkg.
module rgbc_line_store
   import rgbc_pkg::*;
#(
   parameter  int DEPTH  = 1024,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  logic              clock,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  pixel_type         wr_data,
   output pixel_type         rd_upper,
   output pixel_type         rd_lower
);

   pixel_type upper_mem [DEPTH];
   pixel_type lower_mem [DEPTH];
   pixel_type upper_ff;
   pixel_type lower_ff;
   logic      hit;

   assign hit = wr_en && (wr_addr == rd_addr);

   // the upper store takes what the lower store held at this column
   always_ff @(posedge clock) begin
      if (wr_en) begin
         upper_mem[wr_addr] <= lower_ff;
         lower_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         if (hit) begin
            upper_ff <= lower_ff;
            lower_ff <= wr_data;
         end else begin
            upper_ff <= upper_mem[rd_addr];
            lower_ff <= lower_mem[rd_addr];
         end
      end
   end

   assign rd_upper = upper_ff;
   assign rd_lower = lower_ff;

endmodule

[rtl/rgbc_filter.sv]
// Per-channel 3x3 multiply stage and sum/shift/clamp stage.
// Depends on rgbc_pkg.
module rgbc_filter
   import rgbc_pkg::*;
(
   input  logic                clock,
   input  filter_ctrl_type     ctrl,
   input  window_type          window,
   input  logic [WIN_TAPS-1:0] tap_use,
   input  coef_rows_type       coefs,
   output pixel_type           result
);

   logic signed [PROD_W-1:0] prod_ff [CHANNELS][WIN_TAPS];
   logic signed [PROD_W-1:0] prod_in [CHANNELS][WIN_TAPS];
   pixel_type                result_ff;
   pixel_type                result_in;

   always_comb begin
      logic signed [PIX_W:0]        px;
      logic signed [COEF_W-1:0]     cf;
      logic signed [PIX_W+COEF_W:0] full;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         for (int r = 0; r < WIN_ROWS; r++) begin
            for (int c = 0; c < WIN_ROWS; c++) begin
               px   = $signed({1'b0, window[r*WIN_ROWS+c][ch*PIX_W +: PIX_W]});
               cf   = $signed(coefs[r][c*COEF_W +: COEF_W]);
               full = px * cf;
               prod_in[ch][r*WIN_ROWS+c] = tap_use[r*WIN_ROWS+c] ? full[PROD_W-1:0] : '0;
            end
         end
      end
   end

   always_comb begin
      logic signed [SUM_W-1:0]   acc;
      logic [SUM_W-FRAC_W-1:0]   scaled;
      result_in = '0;
      for (int ch = 0; ch < CHANNELS; ch++) begin
         acc = '0;
         for (int k = 0; k < WIN_TAPS; k++) begin
            acc = acc + SUM_W'(prod_ff[ch][k]);
         end
         scaled = acc[SUM_W-1:FRAC_W];
         if (acc[SUM_W-1]) begin
            result_in[ch*PIX_W +: PIX_W] = '0;
         end else if (scaled > (SUM_W-FRAC_W)'(PIX_MAX)) begin
            result_in[ch*PIX_W +: PIX_W] = PIX_MAX;
         end else begin
            result_in[ch*PIX_W +: PIX_W] = scaled[PIX_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.prod_load) begin
         prod_ff <= prod_in;
      end
      if (ctrl.result_load) begin
         result_ff <= result_in;
      end
   end

   assign result = result_ff;

endmodule

[rtl/rgb_convolution_3x3.sv]
// 3x3 zero-padded RGB convolution, streaming in raster order.
// Depends on rgbc_pkg, rgbc_line_store and rgbc_filter.
//
// Pixels enter on req_* in raster order, one transfer each (req_tuser = 0).
// After the frame's last pixel the host sends image_width + 1 flush
// transfers (req_tuser = 1); each releases one pending result, except the
// first one of a one-row frame. A flush before all rows have arrived is
// dropped; a pixel after the last one is treated as a flush. Results leave
// on rsp_* one row plus one pixel behind the input; rsp_tlast marks the
// frame's final result, after which the next transfer starts a new frame.
// One transfer per cycle is sustained while the receiver does not stall:
// each item makes one read and one write of the two line stores at its
// column, and each released result then goes through a multiply stage
// and a sum/clamp stage into the output register.
// When the receiver stalls, bubbles in the pipe still fill, and req_tready
// drops only while the output register and both stages hold results.
// Reset (synchronous) clears the pipe, the counters, the window and the
// registers to their defaults; line store contents need no clearing.
// Registers (64-bit APB, byte address 8 * index): width, height, and three
// coefficient rows of three signed Q8.8 values, left tap in the low bits.
module rgb_convolution_3x3
   import rgbc_pkg::*;
#(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // pix_red, pix_green, pix_blue
   input  logic                  req_tuser,   // command
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [23:0]           rsp_tdata,   // out_red, out_green, out_blue
   output logic                  rsp_tlast,   // frame_end
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int H_W    = $clog2(MAX_HEIGHT + 1);
   localparam int OROW_W = $clog2(MAX_HEIGHT);
   localparam int IROW_W = H_W + 1;
   localparam int WCMP_W = (W_W > WIDTH_REG_W) ? W_W : WIDTH_REG_W;
   localparam int HCMP_W = (H_W > HEIGHT_REG_W) ? H_W : HEIGHT_REG_W;

   // configuration
   logic [WIDTH_REG_W-1:0]  width_ff;
   logic [HEIGHT_REG_W-1:0] height_ff;
   coef_rows_type           coef_ff;
   logic                    csr_write;
   reg_index_type           reg_sel;
   logic [WCMP_W-1:0]       width_ext;
   logic [HCMP_W-1:0]       height_ext;
   logic [W_W-1:0]          eff_w;
   logic [H_W-1:0]          eff_h;

   // counters
   logic [COL_W-1:0]  in_col_ff, in_col_in;
   logic [IROW_W-1:0] in_row_ff, in_row_in;
   logic [COL_W-1:0]  out_col_ff, out_col_in;
   logic [OROW_W-1:0] out_row_ff, out_row_in;

   // intake decisions
   logic                req_fire;
   logic                tail;
   logic                live;
   logic                pix_emit;
   logic                col_wrap;
   logic                top_ok, bot_ok, left_ok, right_ok, frame_last;
   logic [WIN_TAPS-1:0] use_mask;
   pixel_type           pix_data;

   // pipeline
   logic                s1_valid_ff, s1_emit_ff, s1_last_ff;
   logic [WIN_TAPS-1:0] s1_use_ff;
   logic [COL_W-1:0]    s1_col_ff;
   pixel_type           s1_data_ff;
   logic                s2_valid_ff, s2_last_ff;
   logic                out_valid_ff, out_last_ff;
   logic                en1, en2, en3, s1_go;
   window_type          window_ff, window_in;
   pixel_type           above2, above1;
   pixel_type           result;
   filter_ctrl_type     filt_ctrl;

   // ---------------- configuration port ----------------
   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign reg_sel    = reg_index_type'(csr_paddr[CSR_ADDR_W-1:3]);

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff   <= WIDTH_REG_W'(1);
         height_ff  <= HEIGHT_REG_W'(1);
         coef_ff[0] <= '0;
         coef_ff[1] <= COEF_MID_RESET;
         coef_ff[2] <= '0;
      end else if (csr_write) begin
         case (reg_sel)
            REG_WIDTH:       width_ff   <= csr_pwdata[WIDTH_REG_W-1:0];
            REG_HEIGHT:      height_ff  <= csr_pwdata[HEIGHT_REG_W-1:0];
            REG_COEF_TOP:    coef_ff[0] <= csr_pwdata[COEF_ROW_W-1:0];
            REG_COEF_MID:    coef_ff[1] <= csr_pwdata[COEF_ROW_W-1:0];
            REG_COEF_BOTTOM: coef_ff[2] <= csr_pwdata[COEF_ROW_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         REG_WIDTH:       csr_prdata = CSR_DATA_W'(width_ff);
         REG_HEIGHT:      csr_prdata = CSR_DATA_W'(height_ff);
         REG_COEF_TOP:    csr_prdata = CSR_DATA_W'(coef_ff[0]);
         REG_COEF_MID:    csr_prdata = CSR_DATA_W'(coef_ff[1]);
         REG_COEF_BOTTOM: csr_prdata = CSR_DATA_W'(coef_ff[2]);
         default:         csr_prdata = '0;
      endcase
   end

   // sizes in use, clamped to 1..MAX
   assign width_ext  = WCMP_W'(width_ff);
   assign height_ext = HCMP_W'(height_ff);

   always_comb begin
      if (width_ff == '0) begin
         eff_w = W_W'(1);
      end else if (width_ext > WCMP_W'(MAX_WIDTH)) begin
         eff_w = W_W'(MAX_WIDTH);
      end else begin
         eff_w = W_W'(width_ext);
      end
      if (height_ff == '0) begin
         eff_h = H_W'(1);
      end else if (height_ext > HCMP_W'(MAX_HEIGHT)) begin
         eff_h = H_W'(MAX_HEIGHT);
      end else begin
         eff_h = H_W'(height_ext);
      end
   end

   // ---------------- intake ----------------
   assign en3   = ~out_valid_ff | rsp_tready;
   assign en2   = ~s2_valid_ff | en3;
   assign s1_go = s1_valid_ff & (~s1_emit_ff | en2);
   assign en1   = ~s1_valid_ff | s1_go;

   assign req_tready = en1;
   assign req_fire   = req_tvalid & req_tready;
   assign tail       = in_row_ff >= IROW_W'(eff_h);
   assign live       = req_fire & ~(req_tuser & ~tail);
   assign pix_emit   = (in_row_ff >= IROW_W'(2)) ||
                       ((in_row_ff == IROW_W'(1)) && (in_col_ff != '0));
   assign col_wrap   = (W_W'(in_col_ff) + W_W'(1)) >= eff_w;
   assign pix_data   = tail ? '0 : pixel_type'(req_tdata);

   assign top_ok     = out_row_ff != '0;
   assign bot_ok     = (H_W'(out_row_ff) + H_W'(1)) < eff_h;
   assign left_ok    = out_col_ff != '0;
   assign right_ok   = (W_W'(out_col_ff) + W_W'(1)) < eff_w;
   assign frame_last = ~bot_ok & ~right_ok;

   always_comb begin
      logic row_ok;
      for (int r = 0; r < WIN_ROWS; r++) begin
         row_ok = (r == 0) ? top_ok : ((r == WIN_ROWS - 1) ? bot_ok : 1'b1);
         use_mask[r*WIN_ROWS]     = row_ok & left_ok;
         use_mask[r*WIN_ROWS + 1] = row_ok;
         use_mask[r*WIN_ROWS + 2] = row_ok & right_ok;
      end
   end

   always_comb begin
      in_col_in  = in_col_ff;
      in_row_in  = in_row_ff;
      out_col_in = out_col_ff;
      out_row_in = out_row_ff;
      if (live) begin
         if (pix_emit && frame_last) begin
            in_col_in  = '0;
            in_row_in  = '0;
            out_col_in = '0;
            out_row_in = '0;
         end else begin
            if (col_wrap) begin
               in_col_in = '0;
               if (in_row_ff != '1) begin
                  in_row_in = in_row_ff + IROW_W'(1);
               end
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (pix_emit) begin
               if (!right_ok) begin
                  out_col_in = '0;
                  out_row_in = out_row_ff + OROW_W'(1);
               end else begin
                  out_col_in = out_col_ff + COL_W'(1);
               end
            end
         end
      end
   end

   // ---------------- line stores and window ----------------
   rgbc_line_store #(
      .DEPTH (MAX_WIDTH)
   ) u_line_store (
      .clock    (clock),
      .rd_en    (req_fire),
      .rd_addr  (in_col_ff),
      .wr_en    (s1_go),
      .wr_addr  (s1_col_ff),
      .wr_data  (s1_data_ff),
      .rd_upper (above2),
      .rd_lower (above1)
   );

   always_comb begin
      for (int r = 0; r < WIN_ROWS; r++) begin
         window_in[r*WIN_ROWS]     = window_ff[r*WIN_ROWS + 1];
         window_in[r*WIN_ROWS + 1] = window_ff[r*WIN_ROWS + 2];
      end
      window_in[2] = above2;
      window_in[5] = above1;
      window_in[8] = s1_data_ff;
   end

   // ---------------- control registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         window_ff    <= '0;
         in_col_ff    <= '0;
         in_row_ff    <= '0;
         out_col_ff   <= '0;
         out_row_ff   <= '0;
      end else begin
         if (en1) begin
            s1_valid_ff <= live;
         end
         if (en2) begin
            s2_valid_ff <= s1_go & s1_emit_ff;
         end
         if (en3) begin
            out_valid_ff <= s2_valid_ff;
         end
         if (s1_go) begin
            window_ff <= window_in;
         end
         in_col_ff  <= in_col_in;
         in_row_ff  <= in_row_in;
         out_col_ff <= out_col_in;
         out_row_ff <= out_row_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (en1) begin
         s1_emit_ff <= pix_emit;
         s1_last_ff <= frame_last;
         s1_use_ff  <= use_mask;
         s1_col_ff  <= in_col_ff;
         s1_data_ff <= pix_data;
      end
      if (en2) begin
         s2_last_ff <= s1_last_ff;
      end
      if (en3) begin
         out_last_ff <= s2_last_ff;
      end
   end

   // ---------------- filter ----------------
   assign filt_ctrl.prod_load   = en2;
   assign filt_ctrl.result_load = en3;

   rgbc_filter u_filter (
      .clock   (clock),
      .ctrl    (filt_ctrl),
      .window  (window_in),
      .tap_use (s1_use_ff),
      .coefs   (coef_ff),
      .result  (result)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = result;
   assign rsp_tlast  = out_last_ff;

endmodule

[rtl/rgbc_checker.sv]
// Port-level checks for the 3x3 RGB convolution block, bound to the top level.
// Depends on rgb_convolution_3x3.
module rgbc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic        rsp_tlast
);

   // a stalled result transfer keeps its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   // intake only backs off when the output side is full and stalled
   a_ready_backpressure: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("intake stalled without output back-pressure");

   // reset empties the pipe and opens the intake
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && req_tready)
      else $error("pipe not empty after reset");

   // nothing pending after reset and nothing offered in its last cycle: no result may rise
   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      $past(reset) && !$past(req_tvalid) |-> !rsp_tvalid)
      else $error("result without a preceding transfer");

endmodule

bind rgb_convolution_3x3 rgbc_checker u_rgbc_checker (.*);

[verif/rgb_convolution_3x3_tb.sv]
// Self-checking testbench for rgb_convolution_3x3: streams RGB frames, flush and noise
// transfers, predicts every filtered pixel and checks each rsp transfer field by field.
// Depends on rgbc_pkg and the rgb_convolution_3x3 RTL.
module rgb_convolution_3x3_tb;
   import rgbc_pkg::*;

   localparam int MAX_WIDTH        = 1024;
   localparam int MAX_HEIGHT       = 4096;
   localparam int RANDOM_ITEMS     = 900;
   localparam int SETTLE_CYCLES    = 8;
   localparam int LONG_HOLD_CYCLES = 400;
   localparam int WATCHDOG_CYCLES  = 3000;
   localparam int WIDE_FRAME_W     = 48;
   localparam int TALL_FRAME_H     = 48;

   typedef enum logic {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } command_type;

   typedef enum int {
      COEF_SMALL,
      COEF_ANY,
      COEF_EXTREME,
      COEF_BLUR
   } coef_style_type;

   typedef struct {
      pixel_type pix;
      logic      last;
   } filtered_pixel_type;

   // Tracks frame position, line buffers and window; queues the filtered pixel each
   // transfer releases and compares it with what leaves the block.
   class frame_scoreboard;
      logic [WIDTH_REG_W-1:0]  width_reg;
      logic [HEIGHT_REG_W-1:0] height_reg;
      coef_rows_type           coefs;
      logic [23:0]             upper_line[MAX_WIDTH];
      logic [23:0]             lower_line[MAX_WIDTH];
      logic [23:0]             win[WIN_TAPS];
      int unsigned             in_col, in_row, out_col, out_row;
      filtered_pixel_type      expected_q[$];
      int unsigned             failures, pixels, tail_items, dropped, results, frames;

      function new();
         width_reg  = 1;
         height_reg = 1;
         coefs      = '0;
         coefs[1]   = COEF_MID_RESET;
         foreach (upper_line[i]) begin
            upper_line[i] = '0;
            lower_line[i] = '0;
         end
         foreach (win[i]) win[i] = '0;
         in_col  = 0;
         in_row  = 0;
         out_col = 0;
         out_row = 0;
      endfunction

      function void write_reg(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
         case (idx)
            REG_WIDTH:       width_reg = value[WIDTH_REG_W-1:0];
            REG_HEIGHT:      height_reg = value[HEIGHT_REG_W-1:0];
            REG_COEF_TOP:    coefs[0] = value[COEF_ROW_W-1:0];
            REG_COEF_MID:    coefs[1] = value[COEF_ROW_W-1:0];
            REG_COEF_BOTTOM: coefs[2] = value[COEF_ROW_W-1:0];
            default: ;
         endcase
      endfunction

      function logic [CSR_DATA_W-1:0] reg_value(reg_index_type idx);
         case (idx)
            REG_WIDTH:       return CSR_DATA_W'(width_reg);
            REG_HEIGHT:      return CSR_DATA_W'(height_reg);
            REG_COEF_TOP:    return CSR_DATA_W'(coefs[0]);
            REG_COEF_MID:    return CSR_DATA_W'(coefs[1]);
            REG_COEF_BOTTOM: return CSR_DATA_W'(coefs[2]);
            default:         return '0;
         endcase
      endfunction

      function int unsigned active_width();
         if (width_reg < 1) return 1;
         if (width_reg > MAX_WIDTH) return MAX_WIDTH;
         return width_reg;
      endfunction

      function int unsigned active_height();
         if (height_reg < 1) return 1;
         if (height_reg > MAX_HEIGHT) return MAX_HEIGHT;
         return height_reg;
      endfunction

      function bit frame_open();
         return in_row != 0 || in_col != 0;
      endfunction

      function bit in_tail();
         return in_row >= active_height();
      endfunction

      function int unsigned pending();
         return expected_q.size();
      endfunction

      // exact sum of the enabled taps, floor shift, clamp to 0..255
      function logic [7:0] filter_channel(bit use_tap[WIN_TAPS], int ch);
         int sum, px, cf, r, k;
         logic signed [COEF_W-1:0] tap_coef;
         sum = 0;
         for (r = 0; r < WIN_ROWS; r++) begin
            for (k = 0; k < WIN_ROWS; k++) begin
               if (use_tap[r*3+k]) begin
                  px       = win[r*3+k][8*ch +: 8];
                  tap_coef = coefs[r][16*k +: 16];
                  cf       = tap_coef;
                  sum      += px * cf;
               end
            end
         end
         if (sum < 0) return '0;
         sum = sum >>> FRAC_W;
         if (sum > 255) return PIX_MAX;
         return sum[7:0];
      endfunction

      function void note_item(logic cmd, logic [23:0] data);
         int unsigned        w, h, col, r;
         bit                 tail, release_now, top_ok, bot_ok, left_ok, right_ok, row_ok;
         bit                 use_tap[WIN_TAPS];
         logic [23:0]        pix, above2, above1;
         pixel_type          rp;
         filtered_pixel_type res;
         w    = active_width();
         h    = active_height();
         tail = in_row >= h;
         if (cmd == CMD_FLUSH && !tail) begin
            dropped++;
            return;
         end
         if (tail) begin
            pix = '0;
            tail_items++;
         end else begin
            pix = data;
            pixels++;
         end
         col             = (in_col < MAX_WIDTH) ? in_col : 0;
         above2          = upper_line[col];
         above1          = lower_line[col];
         upper_line[col] = above1;
         lower_line[col] = pix;
         for (r = 0; r < WIN_ROWS; r++) begin
            win[r*3]   = win[r*3+1];
            win[r*3+1] = win[r*3+2];
         end
         win[2] = above2;
         win[5] = above1;
         win[8] = pix;
         release_now = in_row >= 2 || (in_row == 1 && in_col >= 1);
         if (in_col + 1 >= w) begin
            in_col = 0;
            in_row++;
         end else begin
            in_col++;
         end
         if (!release_now) return;

         top_ok   = out_row != 0;
         bot_ok   = out_row + 1 < h;
         left_ok  = out_col != 0;
         right_ok = out_col + 1 < w;
         for (r = 0; r < WIN_ROWS; r++) begin
            row_ok         = (r == 0) ? top_ok : (r == 2) ? bot_ok : 1'b1;
            use_tap[r*3]   = row_ok && left_ok;
            use_tap[r*3+1] = row_ok;
            use_tap[r*3+2] = row_ok && right_ok;
         end
         rp.red   = filter_channel(use_tap, 0);
         rp.green = filter_channel(use_tap, 1);
         rp.blue  = filter_channel(use_tap, 2);
         res.pix  = rp;
         res.last = !bot_ok && !right_ok;
         expected_q.push_back(res);

         if (res.last) begin
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            frames++;
         end else if (!right_ok) begin
            out_col = 0;
            out_row++;
         end else begin
            out_col++;
         end
      endfunction

      function void mismatch(string field, logic [7:0] want, logic [7:0] got);
         failures++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      endfunction

      function void check_result(logic [23:0] data, logic last);
         filtered_pixel_type want;
         pixel_type          got;
         got = data;
         if (expected_q.size() == 0) begin
            failures++;
            $display("%0t: unexpected result, expected none actual %h last %b",
                     $time, data, last);
            return;
         end
         want = expected_q.pop_front();
         results++;
         if (got.red !== want.pix.red)     mismatch("out_red", want.pix.red, got.red);
         if (got.green !== want.pix.green) mismatch("out_green", want.pix.green, got.green);
         if (got.blue !== want.pix.blue)   mismatch("out_blue", want.pix.blue, got.blue);
         if (last !== want.last)           mismatch("frame_end", 8'(want.last), 8'(last));
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [23:0]           req_tdata;   // pix_red, pix_green, pix_blue
   logic                  req_tuser;   // command
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [23:0]           rsp_tdata;   // out_red, out_green, out_blue
   logic                  rsp_tlast;   // frame_end
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   frame_scoreboard sb;
   bit              sender_fast;
   bit              results_fast;
   bit              hold_results_armed;
   int unsigned     idle_cycles;
   int unsigned     workload;
   int unsigned     settings, widest, tallest;

   rgb_convolution_3x3 #(
      .MAX_WIDTH  (MAX_WIDTH),
      .MAX_HEIGHT (MAX_HEIGHT)
   ) uut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .rsp_tlast   (rsp_tlast),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // transfer monitor and watchdog
   always @(posedge clock) begin
      bit active;
      active = 1'b0;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            sb.note_item(req_tuser, req_tdata);
            active = 1'b1;
         end
         if (rsp_tvalid && rsp_tready) begin
            sb.check_result(rsp_tdata, rsp_tlast);
            active = 1'b1;
         end
         if (csr_psel && csr_penable) active = 1'b1;
         if (active) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("%0t: watchdog, no transfer for %0d cycles, %0d results outstanding",
                     $time, idle_cycles, sb.pending());
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   // result receiver: random back-pressure, plus one long hold when armed
   initial begin
      int stall;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_results_armed) begin
            hold_results_armed = 1'b0;
            rsp_tready = 1'b0;
            repeat (LONG_HOLD_CYCLES) @(negedge clock);
         end
         stall = results_fast ? 0 : $urandom_range(0, 6);
         if (stall > 0) begin
            rsp_tready = 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready = 1'b1;
         do @(posedge clock); while (!rsp_tvalid);
         @(negedge clock);
      end
   end

   function automatic logic [7:0] draw_channel();
      case ($urandom_range(0, 7))
         0:       return 8'h00;
         1:       return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   function automatic logic [23:0] draw_pixel();
      return {draw_channel(), draw_channel(), draw_channel()};
   endfunction

   function automatic logic [COEF_ROW_W-1:0] draw_coef_row(coef_style_type style);
      logic [COEF_ROW_W-1:0] row;
      int                    k;
      for (k = 0; k < WIN_ROWS; k++) begin
         case (style)
            COEF_SMALL: row[16*k +: 16] = 16'($urandom_range(0, 256)) - 16'd96;
            COEF_ANY:   row[16*k +: 16] = 16'($urandom);
            COEF_EXTREME: begin
               case ($urandom_range(0, 4))
                  0:       row[16*k +: 16] = 16'h8000;
                  1:       row[16*k +: 16] = 16'h7FFF;
                  2:       row[16*k +: 16] = 16'h0000;
                  3:       row[16*k +: 16] = 16'h0100;
                  default: row[16*k +: 16] = 16'hFF00;
               endcase
            end
            default:    row[16*k +: 16] = 16'h001C;
         endcase
      end
      return row;
   endfunction

   task automatic send_item(command_type cmd, logic [23:0] data);
      int gap;
      gap = sender_fast ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req_tvalid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = data;
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
      req_tvalid = 1'b0;
   endtask

   // write one register, then read it back
   task automatic csr_write(reg_index_type idx, logic [CSR_DATA_W-1:0] value);
      csr_psel    = 1'b1;
      csr_pwrite  = 1'b1;
      csr_penable = 1'b0;
      csr_paddr   = {idx, 3'b000};
      csr_pwdata  = value;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      sb.write_reg(idx, value);
      @(negedge clock);
      csr_pwrite  = 1'b0;
      csr_penable = 1'b0;
      @(negedge clock);
      csr_penable = 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== sb.reg_value(idx)) begin
         sb.failures++;
         $display("%0t: register %s readback, expected %h actual %h",
                  $time, idx.name(), sb.reg_value(idx), csr_prdata);
      end
      @(negedge clock);
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
   endtask

   task automatic load_setup(int unsigned w, int unsigned h, logic [COEF_ROW_W-1:0] top,
                             logic [COEF_ROW_W-1:0] mid, logic [COEF_ROW_W-1:0] bottom);
      csr_write(REG_WIDTH, CSR_DATA_W'(w));
      csr_write(REG_HEIGHT, CSR_DATA_W'(h));
      csr_write(REG_COEF_TOP, CSR_DATA_W'(top));
      csr_write(REG_COEF_MID, CSR_DATA_W'(mid));
      csr_write(REG_COEF_BOTTOM, CSR_DATA_W'(bottom));
      settings++;
      if (w > widest) widest = w;
      if (h > tallest) tallest = h;
   endtask

   // wait for every expected pixel, then let transfers that released nothing clear the pipe
   task automatic drain();
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      @(negedge clock);
   endtask

   // finish whatever frame is in progress with pixels and then flushes
   task automatic close_frame();
      while (sb.frame_open())
         send_item(sb.in_tail() ? CMD_FLUSH : CMD_PIXEL, draw_pixel());
   endtask

   // one well-formed frame with sparse early flushes, late pixels and a stray flush
   task automatic stream_frame(int unsigned w, int unsigned h);
      int unsigned n;
      for (n = 0; n < w * h; n++) begin
         if ($urandom_range(0, 32) == 0) send_item(CMD_FLUSH, draw_pixel());
         send_item(CMD_PIXEL, draw_pixel());
      end
      for (n = 0; n <= w; n++)
         send_item(($urandom_range(0, 12) == 0) ? CMD_PIXEL : CMD_FLUSH, draw_pixel());
      if ($urandom_range(0, 19) == 0) send_item(CMD_FLUSH, draw_pixel());
      workload += w * h + w + 1;
   endtask

   initial begin
      int unsigned    w, h, phase, frame_count, n;
      coef_style_type style;
      sb          = new();
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tuser   = CMD_PIXEL;
      csr_psel    = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite  = 1'b0;
      csr_paddr   = '0;
      csr_pwdata  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // reset settings: 1x1 identity; early flush, late pixel, stray flush after frame end
      send_item(CMD_FLUSH, 24'h000000);
      send_item(CMD_PIXEL, 24'hAA00FF);
      send_item(CMD_PIXEL, 24'h123456);
      send_item(CMD_FLUSH, 24'hFFFFFF);
      send_item(CMD_FLUSH, 24'h000000);
      drain();

      // all taps at the positive extreme, pixels at field extremes
      load_setup(2, 2, {3{16'h7FFF}}, {3{16'h7FFF}}, {3{16'h7FFF}});
      send_item(CMD_PIXEL, 24'hFFFFFF);
      send_item(CMD_PIXEL, 24'h000000);
      send_item(CMD_PIXEL, 24'h00FF00);
      send_item(CMD_PIXEL, 24'hFF00FF);
      close_frame();
      drain();

      // width shrink and coefficient change in the middle of the first row
      load_setup(4, 2, {3{16'h001C}}, {3{16'h001C}}, {3{16'h001C}});
      send_item(CMD_PIXEL, 24'h80FF01);
      send_item(CMD_PIXEL, 24'h7F00FE);
      drain();
      csr_write(REG_WIDTH, CSR_DATA_W'(2));
      csr_write(REG_COEF_MID, CSR_DATA_W'({3{16'h8000}}));
      close_frame();
      drain();

      phase = 0;
      while (workload < RANDOM_ITEMS || phase < 10) begin
         phase++;
         sender_fast  = ($urandom_range(0, 3) == 0);
         results_fast = ($urandom_range(0, 3) == 0);
         style        = coef_style_type'($urandom_range(0, 3));
         if (phase == 4) begin
            load_setup(WIDE_FRAME_W, 3, draw_coef_row(style), draw_coef_row(style),
                       draw_coef_row(style));
            hold_results_armed = 1'b1;
            stream_frame(WIDE_FRAME_W, 3);
         end else if (phase == 9) begin
            load_setup(1, TALL_FRAME_H, draw_coef_row(style), draw_coef_row(style),
                       draw_coef_row(style));
            stream_frame(1, TALL_FRAME_H);
         end else begin
            n = $urandom_range(0, 19);
            if (n == 0) w = $urandom_range(33, 100);
            else if (n < 6) w = $urandom_range(7, 32);
            else w = $urandom_range(1, 6);
            h = ($urandom_range(0, 4) == 0) ? $urandom_range(6, 12) : $urandom_range(1, 5);
            load_setup(w, h, draw_coef_row(style), draw_coef_row(style),
                       draw_coef_row(style));
            frame_count = $urandom_range(1, 3);
            repeat (frame_count) begin
               if ($urandom_range(0, 9) == 0) begin
                  repeat ($urandom_range(1, 20))
                     send_item(command_type'($urandom_range(0, 1)), draw_pixel());
                  close_frame();
               end else begin
                  stream_frame(w, h);
               end
            end
            close_frame();
         end
         drain();
      end

      $display("covered %0d frames: %0d pixels, %0d tail transfers, %0d dropped flushes",
               sb.frames, sb.pixels, sb.tail_items, sb.dropped);
      $display("%0d results checked over %0d settings, up to %0d wide and %0d tall",
               sb.results, settings, widest, tallest);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

[filelist.f]
rtl/rgbc_pkg.sv
rtl/rgbc_line_store.sv
rtl/rgbc_filter.sv
rtl/rgb_convolution_3x3.sv
rtl/rgbc_checker.sv
verif/rgb_convolution_3x3_tb.sv
